>>> rtl/sca_pkg.sv
`default_nettype none
package sca_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int ALIGN_BYTES  = 8;
  localparam int ALIGN_LG     = 3;
  localparam int SMALL_LIMIT  = 128;
  localparam int REFILL_COUNT = 20;
  localparam int NUM_CLASSES  = SMALL_LIMIT / ALIGN_BYTES;
  localparam int LINK_DEPTH   = HEAP_BYTES / ALIGN_BYTES;
  localparam int MAX_ROUNDS   = 4;

  localparam int AW  = 17;                      // internal address / link word width
  localparam int CW  = $clog2(NUM_CLASSES);     // class index
  localparam int LW  = $clog2(LINK_DEPTH);      // link memory index
  localparam int BSW = 8;                       // rounded block size
  localparam int KW  = 5;                       // refill counter
  localparam int ACW = 12;                      // carved byte total
  localparam int RW  = 3;                       // round counter

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LARGE = 2'd1,
    ST_OOM   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP_WAIT, S_CHK, S_SCAN, S_SCAN_WAIT,
    S_CNT, S_LINK, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_LARGE, OP_FREE, OP_POP, OP_POP_FIN, OP_GROW,
    OP_SCAN_HIT, OP_SCAN_NEXT, OP_SCAN_FIN, OP_CNT_INIT, OP_CNT,
    OP_CARVE, OP_LINK, OP_OOM, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_large;
    logic is_free;
    logic head_nz;
    logic round_max;
    logic left_ge_bs;
    logic heap_ok;
    logic scan_hit;
    logic scan_last;
    logic cnt_more;
    logic cnt_gt1;
    logic link_last;
  } stat_t;

  // size class of a byte count (count of at least one)
  function automatic logic [CW-1:0] cls_of(input logic [AW-1:0] b);
    logic [AW:0] t;
    logic [AW:0] q;
    t = {1'b0, b} + (AW+1)'(ALIGN_BYTES - 1);
    q = t >> ALIGN_LG;
    if (q == '0) q = (AW+1)'(1);
    q = q - (AW+1)'(1);
    if (q >= (AW+1)'(NUM_CLASSES)) return CW'(NUM_CLASSES - 1);
    return q[CW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/sca_if.sv
`default_nettype none
interface sca_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] size_bytes;
  logic [15:0] block_address;
  modport source (output valid, kind, size_bytes, block_address, input ready);
  modport sink   (input valid, kind, size_bytes, block_address, output ready);
endinterface

interface sca_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] granted_address;
  logic [1:0]  status;
  modport source (output valid, granted_address, status, input ready);
  modport sink   (input valid, granted_address, status, output ready);
endinterface
`default_nettype wire

>>> rtl/sca_ram.sv
`default_nettype none
module sca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/sca_ctrl.sv
`default_nettype none
module sca_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire sca_pkg::stat_t stat,
  output sca_pkg::cmd_t       cmd
);
  sca_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // state and output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sca_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == sca_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // sequencing
  always_comb begin
    state_nxt     = state_r;
    cmd.op        = sca_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      sca_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op    = sca_pkg::OP_LOAD;
          state_nxt = sca_pkg::S_DECODE;
        end
      end
      sca_pkg::S_DECODE: begin
        if (stat.is_large) begin
          cmd.op    = sca_pkg::OP_LARGE;
          state_nxt = sca_pkg::S_DONE;
        end else if (stat.is_free) begin
          cmd.op    = sca_pkg::OP_FREE;
          state_nxt = sca_pkg::S_DONE;
        end else if (stat.head_nz) begin
          cmd.op    = sca_pkg::OP_POP;
          state_nxt = sca_pkg::S_POP_WAIT;
        end else begin
          state_nxt = sca_pkg::S_CHK;
        end
      end
      sca_pkg::S_POP_WAIT: begin
        cmd.op    = sca_pkg::OP_POP_FIN;
        state_nxt = sca_pkg::S_DONE;
      end
      sca_pkg::S_CHK: begin
        if (stat.round_max) begin
          cmd.op    = sca_pkg::OP_OOM;
          state_nxt = sca_pkg::S_DONE;
        end else if (stat.left_ge_bs) begin
          cmd.op    = sca_pkg::OP_CNT_INIT;
          state_nxt = sca_pkg::S_CNT;
        end else begin
          cmd.op    = sca_pkg::OP_GROW;
          state_nxt = stat.heap_ok ? sca_pkg::S_CHK : sca_pkg::S_SCAN;
        end
      end
      sca_pkg::S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.op    = sca_pkg::OP_SCAN_HIT;
          state_nxt = sca_pkg::S_SCAN_WAIT;
        end else if (stat.scan_last) begin
          cmd.op    = sca_pkg::OP_OOM;
          state_nxt = sca_pkg::S_DONE;
        end else begin
          cmd.op    = sca_pkg::OP_SCAN_NEXT;
        end
      end
      sca_pkg::S_SCAN_WAIT: begin
        cmd.op    = sca_pkg::OP_SCAN_FIN;
        state_nxt = sca_pkg::S_CHK;
      end
      sca_pkg::S_CNT: begin
        if (stat.cnt_more) begin
          cmd.op = sca_pkg::OP_CNT;
        end else begin
          cmd.op    = sca_pkg::OP_CARVE;
          state_nxt = stat.cnt_gt1 ? sca_pkg::S_LINK : sca_pkg::S_DONE;
        end
      end
      sca_pkg::S_LINK: begin
        cmd.op = sca_pkg::OP_LINK;
        if (stat.link_last) state_nxt = sca_pkg::S_DONE;
      end
      sca_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = sca_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = sca_pkg::S_IDLE;
        end
      end
      default: state_nxt = sca_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/sca_dp.sv
`default_nettype none
module sca_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_kind,
  input  wire logic [15:0]    in_size,
  input  wire logic [15:0]    in_addr,
  input  wire sca_pkg::cmd_t  cmd,
  output sca_pkg::stat_t      stat,
  output logic [15:0]         out_addr,
  output logic [1:0]          out_status
);
  localparam int AW = sca_pkg::AW;
  localparam int CW = sca_pkg::CW;

  logic [AW-1:0] heads_r [sca_pkg::NUM_CLASSES];
  logic [AW-1:0] heads_nxt [sca_pkg::NUM_CLASSES];
  logic [AW-1:0] pstart_r, pstart_nxt, pend_r, pend_nxt;
  logic [AW-1:0] grown_r, grown_nxt, bump_r, bump_nxt;
  logic [sca_pkg::RW-1:0] round_r, round_nxt;
  logic [CW-1:0] cls_r, cls_nxt, sc_r, sc_nxt;
  logic [sca_pkg::BSW-1:0] bs_r, bs_nxt;
  logic [15:0] baddr_r, baddr_nxt;
  logic large_r, large_nxt, free_r, free_nxt;
  logic [sca_pkg::KW-1:0] cnt_r, cnt_nxt, k_r, k_nxt;
  logic [sca_pkg::ACW-1:0] acc_r, acc_nxt;
  logic [AW-1:0] walk_r, walk_nxt, grant_r, grant_nxt;
  logic [1:0] status_r, status_nxt;
  logic [15:0] oaddr_r, oaddr_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic rd_far_r;

  logic [AW-1:0] left, hc, hs, sz1;
  logic [AW:0] sz_ru;
  logic [CW-1:0] lcls;
  logic [12:0] total;
  logic [13:0] ru16;
  logic [14:0] get;
  logic [AW:0] bump_sum;
  logic [AW:0] acc_sum;
  logic [AW-1:0] rd_link;
  logic [AW-1:0] raddr_full, waddr_full, wdata;
  logic we;
  logic [AW-1:0] rdata;

  // link memory: one word per aligned slot
  sca_ram #(.WIDTH(AW), .DEPTH(sca_pkg::LINK_DEPTH)) u_link (
    .clk(clk), .we(we),
    .waddr(waddr_full[sca_pkg::ALIGN_LG +: sca_pkg::LW]), .wdata(wdata),
    .raddr(raddr_full[sca_pkg::ALIGN_LG +: sca_pkg::LW]), .rdata(rdata)
  );

  // slot beyond the heap reads as end of list
  always_ff @(posedge clk) rd_far_r <= (raddr_full >= AW'(sca_pkg::HEAP_BYTES));
  assign rd_link = rd_far_r ? '0 : rdata;

  // shared arithmetic
  always_comb begin
    left     = pend_r - pstart_r;
    hc       = heads_r[cls_r];
    hs       = heads_r[sc_r];
    lcls     = sca_pkg::cls_of(left);
    total    = 13'(bs_r) * 13'(sca_pkg::REFILL_COUNT);
    ru16     = (14'(grown_r >> 4) + 14'(sca_pkg::ALIGN_BYTES - 1))
               & ~14'(sca_pkg::ALIGN_BYTES - 1);
    get      = {1'b0, total, 1'b0} + 15'(ru16);
    bump_sum = {1'b0, bump_r} + (AW+1)'(get);
    acc_sum  = (AW+1)'(acc_r) + (AW+1)'(bs_r);
    sz1      = (in_size == 16'd0) ? AW'(1) : AW'(in_size);
    sz_ru    = ({1'b0, sz1} + (AW+1)'(sca_pkg::ALIGN_BYTES - 1))
               & ~(AW+1)'(sca_pkg::ALIGN_BYTES - 1);
  end

  // flags to the controller
  always_comb begin
    stat.is_large   = large_r;
    stat.is_free    = free_r;
    stat.head_nz    = (hc != '0);
    stat.round_max  = (round_r == sca_pkg::RW'(sca_pkg::MAX_ROUNDS));
    stat.left_ge_bs = (left >= AW'(bs_r));
    stat.heap_ok    = (bump_sum <= (AW+1)'(sca_pkg::HEAP_BYTES));
    stat.scan_hit   = (hs != '0);
    stat.scan_last  = (sc_r == CW'(sca_pkg::NUM_CLASSES - 1));
    stat.cnt_more   = (cnt_r < sca_pkg::KW'(sca_pkg::REFILL_COUNT))
                      && (acc_sum <= (AW+1)'(left));
    stat.cnt_gt1    = (cnt_r > sca_pkg::KW'(1));
    stat.link_last  = ((k_r + sca_pkg::KW'(1)) == cnt_r);
  end

  // operation decode
  always_comb begin
    for (int i = 0; i < sca_pkg::NUM_CLASSES; i++) heads_nxt[i] = heads_r[i];
    pstart_nxt = pstart_r;  pend_nxt  = pend_r;
    grown_nxt  = grown_r;   bump_nxt  = bump_r;
    round_nxt  = round_r;   cls_nxt   = cls_r;   sc_nxt = sc_r;
    bs_nxt     = bs_r;      baddr_nxt = baddr_r;
    large_nxt  = large_r;   free_nxt  = free_r;
    cnt_nxt    = cnt_r;     k_nxt     = k_r;     acc_nxt = acc_r;
    walk_nxt   = walk_r;    grant_nxt = grant_r; status_nxt = status_r;
    oaddr_nxt  = oaddr_r;   ostat_nxt = ostat_r;
    we = 1'b0; waddr_full = '0; wdata = '0; raddr_full = '0;
    unique case (cmd.op)
      sca_pkg::OP_LOAD: begin
        large_nxt  = (sz1 > AW'(sca_pkg::SMALL_LIMIT));
        free_nxt   = in_kind;
        cls_nxt    = sca_pkg::cls_of(sz1);
        bs_nxt     = sz_ru[sca_pkg::BSW-1:0];
        baddr_nxt  = in_addr & ~16'(sca_pkg::ALIGN_BYTES - 1);
        grant_nxt  = '0;
        status_nxt = sca_pkg::ST_OK;
        round_nxt  = '0;
      end
      sca_pkg::OP_LARGE: status_nxt = sca_pkg::ST_LARGE;
      sca_pkg::OP_FREE: begin
        if (AW'(baddr_r) < AW'(sca_pkg::HEAP_BYTES)) begin
          we = 1'b1; waddr_full = AW'(baddr_r); wdata = hc;
          heads_nxt[cls_r] = AW'(baddr_r) + AW'(1);
        end
      end
      sca_pkg::OP_POP: begin
        grant_nxt  = hc - AW'(1);
        raddr_full = hc - AW'(1);
      end
      sca_pkg::OP_POP_FIN: heads_nxt[cls_r] = rd_link;
      sca_pkg::OP_GROW: begin
        // leftover onto its own list, then take from the heap
        if (left != '0) begin
          we = (pstart_r < AW'(sca_pkg::HEAP_BYTES));
          waddr_full = pstart_r; wdata = heads_r[lcls];
          heads_nxt[lcls] = pstart_r + AW'(1);
        end
        // class of the rounded block size equals the request class
        sc_nxt = cls_r;
        if (stat.heap_ok) begin
          pstart_nxt = bump_r;
          bump_nxt   = bump_sum[AW-1:0];
          grown_nxt  = grown_r + AW'(get);
          pend_nxt   = bump_sum[AW-1:0];
          round_nxt  = round_r + sca_pkg::RW'(1);
        end
      end
      sca_pkg::OP_SCAN_HIT: begin
        raddr_full = hs - AW'(1);
        pstart_nxt = hs - AW'(1);
        pend_nxt   = hs - AW'(1) + (AW'({1'b0, sc_r} + 1'b1) << sca_pkg::ALIGN_LG);
      end
      sca_pkg::OP_SCAN_NEXT: sc_nxt = sc_r + CW'(1);
      sca_pkg::OP_SCAN_FIN: begin
        heads_nxt[sc_r] = rd_link;
        round_nxt       = round_r + sca_pkg::RW'(1);
      end
      sca_pkg::OP_CNT_INIT: begin
        cnt_nxt = '0;
        acc_nxt = '0;
      end
      sca_pkg::OP_CNT: begin
        cnt_nxt = cnt_r + sca_pkg::KW'(1);
        acc_nxt = acc_sum[sca_pkg::ACW-1:0];
      end
      sca_pkg::OP_CARVE: begin
        grant_nxt  = pstart_r;
        pstart_nxt = pstart_r + AW'(acc_r);
        if (cnt_r > sca_pkg::KW'(1))
          heads_nxt[cls_r] = pstart_r + AW'(bs_r) + AW'(1);
        walk_nxt = pstart_r + AW'(bs_r);
        k_nxt    = sca_pkg::KW'(1);
      end
      sca_pkg::OP_LINK: begin
        we = (walk_r < AW'(sca_pkg::HEAP_BYTES));
        waddr_full = walk_r;
        wdata = stat.link_last ? '0 : walk_r + AW'(bs_r) + AW'(1);
        walk_nxt = walk_r + AW'(bs_r);
        k_nxt    = k_r + sca_pkg::KW'(1);
      end
      sca_pkg::OP_OOM: begin
        pstart_nxt = '0;
        pend_nxt   = '0;
        grant_nxt  = '0;
        status_nxt = sca_pkg::ST_OOM;
      end
      sca_pkg::OP_OUT: begin
        oaddr_nxt = grant_r[15:0];
        ostat_nxt = status_r;
      end
      default: ;
    endcase
  end

  // state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sca_pkg::NUM_CLASSES; i++) heads_r[i] <= '0;
      pstart_r <= '0;
      pend_r   <= '0;
      grown_r  <= '0;
      bump_r   <= '0;
    end else begin
      for (int i = 0; i < sca_pkg::NUM_CLASSES; i++) heads_r[i] <= heads_nxt[i];
      pstart_r <= pstart_nxt;
      pend_r   <= pend_nxt;
      grown_r  <= grown_nxt;
      bump_r   <= bump_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    round_r  <= round_nxt;  cls_r   <= cls_nxt;   sc_r    <= sc_nxt;
    bs_r     <= bs_nxt;     baddr_r <= baddr_nxt;
    large_r  <= large_nxt;  free_r  <= free_nxt;
    cnt_r    <= cnt_nxt;    k_r     <= k_nxt;     acc_r   <= acc_nxt;
    walk_r   <= walk_nxt;   grant_r <= grant_nxt; status_r <= status_nxt;
    oaddr_r  <= oaddr_nxt;  ostat_r <= ostat_nxt;
  end

  assign out_addr   = oaddr_r;
  assign out_status = ostat_r;
endmodule
`default_nettype wire

>>> rtl/size_class_free_list_allocator.sv
`default_nettype none
// channel   dir  handshake      payload
// in_ch     in   valid/ready    kind, size_bytes, block_address
// out_ch    out  valid/ready    granted_address, status
//
// One item at a time: free, large request and list pop go straight to
// the result. A refill counts up to 20 blocks and links them one by one
// through the link memory write port; each round grows the heap or
// scans the lists (up to 16 classes), at most four rounds.
// Synchronous active-low reset empties all lists, pool and heap.
// A waiting result sits in the output register; the next item is taken
// meanwhile and holds at its end until that register is free.
module size_class_free_list_allocator (
  input wire logic clk,
  input wire logic rst_n,
  sca_req_if.sink   in_ch,
  sca_rsp_if.source out_ch
);
  sca_pkg::cmd_t  cmd;
  sca_pkg::stat_t stat;

  sca_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  sca_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_kind(in_ch.kind), .in_size(in_ch.size_bytes), .in_addr(in_ch.block_address),
    .cmd(cmd), .stat(stat),
    .out_addr(out_ch.granted_address), .out_status(out_ch.status)
  );

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item taken while another is in work");

  // no undefined status code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status != 2'd3)
    else $error("bad status code");

  // no address unless granted
  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != sca_pkg::ST_OK |-> out_ch.granted_address == 16'd0)
    else $error("address on failed request");
endmodule
`default_nettype wire
